FILE: hw/rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted cost priority list: shared definitions
// Request kinds, result status codes, port field widths and the control
// bundle that the list controller broadcasts to every cell.
// ----------------------------------------------------------------------------
package scl_pkg;

  // Port field widths, fixed by the interface definition.
  localparam int KIND_W   = 3;
  localparam int COORD_W  = 10;
  localparam int COST_W   = 16;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Default storage parameters.
  localparam int DEF_DEPTH      = 32;
  localparam int DEF_COORD_BITS = 10;
  localparam int DEF_COST_BITS  = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_POP    = 3'd1,
    KIND_FIND   = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Broadcast control for one cycle of the cell chain.
  typedef struct packed {
    logic ins;   // insert the new record at its sorted place
    logic clr;   // drop every entry
  } cell_ctl_t;

endpackage

FILE: hw/rtl/scl_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one list operation and its operands.
// ----------------------------------------------------------------------------
interface scl_req_if
  import scl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COORD_W-1:0]  x;
  logic [COORD_W-1:0]  y;
  logic [COST_W-1:0]   cost;
  logic [HANDLE_W-1:0] record_handle;

  modport source (output valid, kind, x, y, cost, record_handle, input ready);
  modport sink   (input valid, kind, x, y, cost, record_handle, output ready);
endinterface

FILE: hw/rtl/scl_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the outcome of one list operation.
// ----------------------------------------------------------------------------
interface scl_rsp_if
  import scl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [COST_W-1:0]   out_cost;
  logic [HANDLE_W-1:0] out_handle;
  logic                list_empty;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_x, out_y, out_cost, out_handle,
                  list_empty, entry_count, input ready);
  modport sink   (input valid, status, out_x, out_y, out_cost, out_handle,
                  list_empty, entry_count, output ready);
endinterface

FILE: hw/rtl/scl_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one record and its valid bit. On insert it keeps, takes the new
// record or takes its left neighbor's; on removal it takes its right
// neighbor's. Reports the local compare results to the controller.
// ----------------------------------------------------------------------------
module scl_cell
  import scl_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COST_BITS  = DEF_COST_BITS,
  parameter int REC_W      = 2 * COORD_BITS + COST_BITS + HANDLE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [REC_W-1:0] new_rec,
  input  logic             take,
  input  logic [REC_W-1:0] left_rec,
  input  logic             left_valid,
  input  logic             left_keep,
  input  logic [REC_W-1:0] right_rec,
  input  logic             right_valid,
  output logic [REC_W-1:0] rec,
  output logic             valid,
  output logic             keep,
  output logic             match_xy,
  output logic             match_handle
);
  localparam int C_LO = HANDLE_W;
  localparam int Y_LO = C_LO + COST_BITS;
  localparam int X_LO = Y_LO + COORD_BITS;

  // The entry stays put on insert when it sorts at or before the new record.
  assign keep = valid && (rec[C_LO +: COST_BITS] <= new_rec[C_LO +: COST_BITS]);

  assign match_xy = valid
                    && (rec[X_LO +: COORD_BITS] == new_rec[X_LO +: COORD_BITS])
                    && (rec[Y_LO +: COORD_BITS] == new_rec[Y_LO +: COORD_BITS]);

  assign match_handle = valid && (rec[HANDLE_W-1:0] == new_rec[HANDLE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= valid | left_valid;
    end else if (take) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !keep) begin
      rec <= left_keep ? new_rec : left_rec;
    end else if (take) begin
      rec <= right_rec;
    end
  end

endmodule

FILE: hw/rtl/sorted_cost_priority_list.sv
// ----------------------------------------------------------------------------
// Sorted cost priority list
// Bounded open list for path search, kept sorted by ascending cost in a
// chain of cells, with insert, pop minimum, find, delete and clear.
// ----------------------------------------------------------------------------
// Every request is handled in one pass: all cells compare against the
// broadcast operands at once and shift left or right on the same edge,
// which also registers the result. The block takes one request per
// cycle as long as the result register is empty or being drained; it
// stalls only while an earlier result waits to be taken. Equal costs
// leave in insertion order. No clearing pass is needed after reset.
module sorted_cost_priority_list
  import scl_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COST_BITS  = DEF_COST_BITS
) (
  input  logic      clk,
  input  logic      rst,
  scl_req_if.sink   req,
  scl_rsp_if.source rsp
);
  localparam int REC_W = 2 * COORD_BITS + COST_BITS + HANDLE_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int C_LO  = HANDLE_W;
  localparam int Y_LO  = C_LO + COST_BITS;
  localparam int X_LO  = Y_LO + COORD_BITS;

  logic [REC_W-1:0] recs [DEPTH];
  logic [DEPTH-1:0] valid_v;
  logic [DEPTH-1:0] keep_v;
  logic [DEPTH-1:0] mxy_v;
  logic [DEPTH-1:0] mh_v;
  logic [DEPTH-1:0] take_v;
  logic [DEPTH-1:0] hit_v;
  logic [DEPTH-1:0] first_v;

  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic [REC_W-1:0] new_rec;
  logic [REC_W-1:0] hit_rec;
  logic             accept;
  logic             full;
  logic             found;
  logic             do_remove;
  logic             show_hit;
  cell_ctl_t        ctl;
  status_t          status_next;

  assign accept = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign full = (held == CNT_W'(DEPTH));

  assign new_rec = {COORD_BITS'(req.x), COORD_BITS'(req.y),
                    COST_BITS'(req.cost), req.record_handle};

  // Lowest set bit of the hit vector marks the first entry in list order.
  assign first_v = hit_v & (~hit_v + 1'b1);
  assign found   = |hit_v;
  assign take_v  = do_remove ? ~(first_v - 1'b1) : '0;

  always_comb begin
    hit_v       = '0;
    ctl.ins     = 1'b0;
    ctl.clr     = 1'b0;
    do_remove   = 1'b0;
    show_hit    = 1'b0;
    status_next = ST_OK;
    held_next   = held;
    case (req.kind)
      KIND_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins   = accept;
          held_next = held + 1'b1;
        end
      end
      KIND_POP: begin
        hit_v[0]  = valid_v[0];
        do_remove = accept;
        show_hit  = 1'b1;
      end
      KIND_FIND: begin
        hit_v    = mxy_v;
        show_hit = 1'b1;
      end
      KIND_DELETE: begin
        hit_v     = mh_v;
        do_remove = accept;
      end
      KIND_CLEAR: begin
        ctl.clr   = accept;
        held_next = '0;
      end
      default: begin
      end
    endcase
    if ((req.kind == KIND_POP) || (req.kind == KIND_FIND)
        || (req.kind == KIND_DELETE)) begin
      if (!found) begin
        status_next = ST_MISS;
      end else if (req.kind != KIND_FIND) begin
        held_next = held - 1'b1;
      end
    end
  end

  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_rec = hit_rec | (first_v[i] ? recs[i] : '0);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [REC_W-1:0] left_rec;
    logic [REC_W-1:0] right_rec;
    logic             left_valid;
    logic             left_keep;
    logic             right_valid;

    if (i == 0) begin : g_head
      assign left_rec   = new_rec;
      assign left_valid = 1'b1;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_rec   = recs[i-1];
      assign left_valid = valid_v[i-1];
      assign left_keep  = keep_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec   = recs[i];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_rec   = recs[i+1];
      assign right_valid = valid_v[i+1];
    end

    scl_cell #(
      .COORD_BITS(COORD_BITS),
      .COST_BITS (COST_BITS),
      .REC_W     (REC_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_rec     (new_rec),
      .take        (take_v[i]),
      .left_rec    (left_rec),
      .left_valid  (left_valid),
      .left_keep   (left_keep),
      .right_rec   (right_rec),
      .right_valid (right_valid),
      .rec         (recs[i]),
      .valid       (valid_v[i]),
      .keep        (keep_v[i]),
      .match_xy    (mxy_v[i]),
      .match_handle(mh_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        held      <= held_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.list_empty  <= (held_next == '0);
      rsp.entry_count <= COUNT_W'(held_next);
      if (show_hit && found) begin
        rsp.out_x      <= COORD_W'(hit_rec[X_LO +: COORD_BITS]);
        rsp.out_y      <= COORD_W'(hit_rec[Y_LO +: COORD_BITS]);
        rsp.out_cost   <= COST_W'(hit_rec[C_LO +: COST_BITS]);
        rsp.out_handle <= hit_rec[HANDLE_W-1:0];
      end else begin
        rsp.out_x      <= '0;
        rsp.out_y      <= '0;
        rsp.out_cost   <= '0;
        rsp.out_handle <= '0;
      end
    end
  end

  // The valid cells always number exactly the entry count.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_v) == held)
    else $error("cell valid bits disagree with entry count");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("entry count beyond list depth");

  // The valid cells form a prefix, so the head is occupied whenever any is.
  a_head_occupied: assert property (@(posedge clk) disable iff (rst)
    (held != '0) |-> valid_v[0])
    else $error("list not packed toward the head");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.kind == KIND_CLEAR)) |=> (held == '0) && (valid_v == '0))
    else $error("clear left entries behind");

endmodule
